FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define BMG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define BMG_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/bmg_pkg.sv
// Shared types, constants and a helper function of the Gaussian sample unit.
package bmg_pkg;

    localparam int LOG_FRAC    = 28;
    localparam int LOG_W       = 5 + LOG_FRAC;
    localparam int COS_TERMS   = 12;
    localparam int SQRT_STEPS  = 32;

    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // Stage counts of each path
    localparam int LOG2_LAT   = LOG_FRAC + 1;
    localparam int COS_LAT    = 5 + 3 * COS_TERMS + 1;
    localparam int RAD_LAT    = LOG2_LAT + 2 + SQRT_STEPS;
    localparam int ALIGN_LAT  = RAD_LAT - COS_LAT;
    localparam int RESULT_LAT = RAD_LAT + 2;

    // Control that travels with each word down the radius path
    typedef struct packed {
        logic valid;
        logic zero;
    } bmg_ctl_t;

    // Fixed-point log2 in Q.28, evaluated at elaboration for the full-scale code
    function automatic logic [LOG_W-1:0] log2_q28(input logic [31:0] v);
        logic [4:0]          e;
        logic [63:0]         m;
        logic [LOG_FRAC-1:0] frac;
        e    = '0;
        frac = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                e = 5'(i);
            end
        end
        m = 64'(v) << (5'd31 - e);
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m    = (m * m) >> 31;
            frac = {frac[LOG_FRAC-2:0], 1'b0};
            if (m[32])
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {e, frac};
    endfunction

endpackage

FILE: design/bmg_log2.sv
// Pipelined log2 in Q.28: normalize, then one mantissa squaring per stage.
module bmg_log2 #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bmg_pkg::bmg_ctl_t           ctl_in,
    input  logic [UNIFORM_BITS-1:0]     value,
    output bmg_pkg::bmg_ctl_t           ctl_out,
    output logic [bmg_pkg::LOG_W-1:0]   log_out
);
    import bmg_pkg::*;

    logic [31:0] v32;
    logic [4:0]  top_idx;
    logic [31:0] norm;

    bmg_ctl_t            ctl_reg  [0:LOG_FRAC];
    logic [31:0]         m_reg    [0:LOG_FRAC];
    logic [4:0]          e_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];

    // Find the leading one and normalize the mantissa to [2^31, 2^32)
    always_comb
    begin
        v32     = 32'(value);
        top_idx = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v32[i])
            begin
                top_idx = 5'(i);
            end
        end
        norm = v32 << (5'd31 - top_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0]    <= norm;
        e_reg[0]    <= top_idx;
        frac_reg[0] <= '0;
    end

    // Square the mantissa once per stage and shift out one fraction bit
    for (genvar g = 1; g <= LOG_FRAC; g++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] sh;
        logic        bit_next;
        logic [31:0] m_next;

        assign sq       = m_reg[g-1] * m_reg[g-1];
        assign sh       = sq[63:31];
        assign bit_next = sh[32];
        assign m_next   = bit_next ? sh[32:1] : sh[31:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else
            begin
                ctl_reg[g] <= ctl_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[g]    <= m_next;
            e_reg[g]    <= e_reg[g-1];
            frac_reg[g] <= {frac_reg[g-1][LOG_FRAC-2:0], bit_next};
        end
    end

    assign ctl_out = ctl_reg[LOG_FRAC];
    assign log_out = {e_reg[LOG_FRAC], frac_reg[LOG_FRAC]};

endmodule

FILE: design/bmg_sqrt.sv
// Pipelined integer square root, one result bit resolved per stage.
module bmg_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  bmg_pkg::bmg_ctl_t ctl_in,
    input  logic [61:0]       radicand,
    output bmg_pkg::bmg_ctl_t ctl_out,
    output logic [30:0]       root
);
    import bmg_pkg::*;

    bmg_ctl_t    ctl_reg [0:SQRT_STEPS-1];
    logic [63:0] rem_reg [0:SQRT_STEPS-1];
    logic [63:0] res_reg [0:SQRT_STEPS-1];

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);

        bmg_ctl_t    ctl_in_s;
        logic [63:0] rem_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic        take;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        if (g == 0)
        begin : g_first
            assign ctl_in_s = ctl_in;
            assign rem_in   = 64'(radicand);
            assign res_in   = '0;
        end
        else
        begin : g_rest
            assign ctl_in_s = ctl_reg[g-1];
            assign rem_in   = rem_reg[g-1];
            assign res_in   = res_reg[g-1];
        end

        // Subtract the trial value when it fits and set this root bit
        assign trial    = res_in + BIT;
        assign take     = rem_in >= trial;
        assign rem_next = take ? rem_in - trial : rem_in;
        assign res_next = take ? (res_in >> 1) + BIT : res_in >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else
            begin
                ctl_reg[g] <= ctl_in_s;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            res_reg[g] <= res_next;
        end
    end

    assign ctl_out = ctl_reg[SQRT_STEPS-1];
    assign root    = res_reg[SQRT_STEPS-1][30:0];

endmodule

FILE: design/bmg_cos.sv
// Pipelined phase scaling, quadrant fold and Taylor-series cosine in Q.30.
module bmg_cos #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                     clk,
    input  logic [UNIFORM_BITS-1:0]  angle,
    output logic signed [31:0]       cos_val
);
    import bmg_pkg::*;

    localparam int          U     = UNIFORM_BITS;
    localparam logic [63:0] M64   = (64'd1 << U) - 64'd1;
    localparam logic [32:0] PH_A  = 33'((64'd1 << 32) / M64);
    localparam int          PH_B  = 32 % U;
    localparam logic [U-1:0] M_U  = M64[U-1:0];
    localparam logic [U:0]  M_1   = {1'b0, M_U};
    localparam logic [U:0]  M_2   = {M_U, 1'b0};

    typedef struct packed {
        logic [31:0]        x2;
        logic               neg;
        logic signed [35:0] sum;
    } cos_side_t;

    // Phase stage 1: split code * 2^32 / M into a product and a small remainder
    logic [2*U-1:0] sh_x;
    logic [63:0]    pa_full;
    logic [U:0]     s_next;
    logic [31:0]    pa_reg;
    logic [U-1:0]   hi_reg;
    logic [U:0]     s_reg;

    assign sh_x    = (2*U)'(angle) << PH_B;
    assign pa_full = angle * PH_A;
    assign s_next  = {1'b0, sh_x[2*U-1:U]} + {1'b0, sh_x[U-1:0]};

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_full[31:0];
        hi_reg <= sh_x[2*U-1:U];
        s_reg  <= s_next;
    end

    // Phase stage 2: correct the remainder quotient and add
    logic [U:0]  qp;
    logic [31:0] p_reg;

    always_comb
    begin
        qp = {1'b0, hi_reg};
        if (s_reg >= M_2)
        begin
            qp = qp + (U+1)'(2);
        end
        else if (s_reg >= M_1)
        begin
            qp = qp + (U+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= pa_reg + 32'(qp);
    end

    // Fold the phase into the first quadrant, note the sign
    logic [31:0] p1;
    logic        big;
    logic [30:0] pf_reg;
    logic        neg_reg;

    assign p1  = p_reg[31] ? (32'd0 - p_reg) : p_reg;
    assign big = p1 > 32'h4000_0000;

    always_ff @(posedge clk)
    begin
        pf_reg  <= big ? 31'(32'h8000_0000 - p1) : p1[30:0];
        neg_reg <= big;
    end

    // Scale turns to radians
    logic [62:0] xp;
    logic [30:0] x_reg;
    logic        neg_x_reg;

    assign xp = pf_reg * TWO_PI_Q29;

    always_ff @(posedge clk)
    begin
        x_reg     <= xp[61:31];
        neg_x_reg <= neg_reg;
    end

    // Square the angle
    logic [61:0] x2p;
    logic [31:0] x2_reg;
    logic        neg_x2_reg;

    assign x2p = x_reg * x_reg;

    always_ff @(posedge clk)
    begin
        x2_reg     <= x2p[61:30];
        neg_x2_reg <= neg_x_reg;
    end

    // Series terms: multiply by x^2, divide by the factorial step, accumulate
    logic [33:0] a_t_reg    [1:COS_TERMS];
    cos_side_t   a_side_reg [1:COS_TERMS];
    logic [33:0] b_t_reg    [1:COS_TERMS];
    logic [33:0] b_q0_reg   [1:COS_TERMS];
    cos_side_t   b_side_reg [1:COS_TERMS];
    logic [31:0] c_term_reg [1:COS_TERMS];
    cos_side_t   c_side_reg [1:COS_TERMS];

    for (genvar k = 1; k <= COS_TERMS; k++)
    begin : g_term
        localparam int          DK  = (2 * k - 1) * (2 * k);
        localparam logic [33:0] D_K = 34'(DK);
        localparam logic [33:0] R_K = 34'((64'd1 << 34) / DK);

        logic [31:0]        term_in;
        cos_side_t          side_in;
        cos_side_t          side_a;
        logic [63:0]        tp;
        logic [67:0]        pb;
        logic [33:0]        rem;
        logic [33:0]        q;

        if (k == 1)
        begin : g_first
            assign term_in = 32'd1 << 30;
            assign side_in = '{x2: x2_reg, neg: neg_x2_reg, sum: 36'sd1 <<< 30};
            assign side_a  = side_in;
        end
        else
        begin : g_rest
            assign term_in = c_term_reg[k-1];
            assign side_in = c_side_reg[k-1];
            // Add the previous term with its alternating sign
            always_comb
            begin
                side_a = side_in;
                if (((k - 1) % 2) == 1)
                begin
                    side_a.sum = side_in.sum - $signed({4'd0, term_in});
                end
                else
                begin
                    side_a.sum = side_in.sum + $signed({4'd0, term_in});
                end
            end
        end

        assign tp  = term_in * side_in.x2;
        assign pb  = a_t_reg[k] * R_K;
        assign rem = b_t_reg[k] - b_q0_reg[k] * D_K;
        assign q   = b_q0_reg[k] + 34'(rem >= D_K);

        always_ff @(posedge clk)
        begin
            a_t_reg[k]    <= tp[63:30];
            a_side_reg[k] <= side_a;
            b_t_reg[k]    <= a_t_reg[k];
            b_q0_reg[k]   <= pb[67:34];
            b_side_reg[k] <= a_side_reg[k];
            c_term_reg[k] <= q[31:0];
            c_side_reg[k] <= b_side_reg[k];
        end
    end

    // Add the last term, clamp to [0, 1.0] and apply the sign
    logic signed [35:0] sum_f;
    logic signed [35:0] sum_c;

    always_comb
    begin
        sum_f = c_side_reg[COS_TERMS].sum + $signed({4'd0, c_term_reg[COS_TERMS]});
        sum_c = sum_f;
        if (sum_f < 0)
        begin
            sum_c = '0;
        end
        else if (sum_f > (36'sd1 <<< 30))
        begin
            sum_c = 36'sd1 <<< 30;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_val <= c_side_reg[COS_TERMS].neg ? -sum_c[31:0] : sum_c[31:0];
    end

endmodule

FILE: design/box_muller_gaussian_sample_unit.sv
// done is registered from the valid bit of the multiply stage.
// Throughput: one word per cycle; busy stays low, the radius path
//   (28 log2 squaring stages and 32 square-root stages) sets the depth.
// Results appear on done for one cycle and cannot be held off.
// Reset clears the valid bits of the pipeline at once; data registers hold.
module box_muller_gaussian_sample_unit #(
    parameter int UNIFORM_BITS  = 16,
    parameter int OUT_FRAC_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [UNIFORM_BITS-1:0]  radius_uniform,
    input  logic [UNIFORM_BITS-1:0]  angle_uniform,
    output logic                     done,
    output logic signed [15:0]       gauss_sample,
    output logic                     saturated
);
    import bmg_pkg::*;

    localparam logic [63:0]      FULL64  = (64'd1 << UNIFORM_BITS) - 64'd1;
    localparam logic [LOG_W-1:0] LOG_MAX = log2_q28(FULL64[31:0]);
    localparam int               SHIFT   = 58 - OUT_FRAC_BITS;
    localparam logic [62:0]      RND     = 63'd1 << (57 - OUT_FRAC_BITS);

    bmg_ctl_t ctl_in;

    assign busy          = 1'b0;
    assign ctl_in.valid  = start & ~busy;
    assign ctl_in.zero   = radius_uniform == '0;

    // Radius path: log2 of the code
    bmg_ctl_t         log_ctl;
    logic [LOG_W-1:0] log_val;

    bmg_log2 #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in),
        .value   (radius_uniform),
        .ctl_out (log_ctl),
        .log_out (log_val)
    );

    // Subtract from the full-scale log, clamp at zero
    bmg_ctl_t         d_ctl_reg;
    logic [LOG_W-1:0] d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctl_reg <= '0;
        end
        else
        begin
            d_ctl_reg <= log_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= (LOG_MAX > log_val) ? LOG_MAX - log_val : '0;
    end

    // Scale by 2 ln 2 to get -2 ln u1
    bmg_ctl_t    r2_ctl_reg;
    logic [62:0] r2_prod;
    logic [33:0] r2_reg;

    assign r2_prod = d_reg * LN2_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_ctl_reg <= '0;
        end
        else
        begin
            r2_ctl_reg <= d_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= r2_prod[62:29];
    end

    // Square root gives the radius in Q.28
    bmg_ctl_t    sq_ctl;
    logic [30:0] root;

    bmg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (r2_ctl_reg),
        .radicand ({r2_reg, 28'd0}),
        .ctl_out  (sq_ctl),
        .root     (root)
    );

    // Angle path: cosine, then delay to meet the radius
    logic signed [31:0] cos_val;
    logic signed [31:0] cos_dly_reg [0:ALIGN_LAT-1];

    bmg_cos #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_cos (
        .clk     (clk),
        .angle   (angle_uniform),
        .cos_val (cos_val)
    );

    always_ff @(posedge clk)
    begin
        cos_dly_reg[0] <= cos_val;
        for (int i = 1; i < ALIGN_LAT; i++)
        begin
            cos_dly_reg[i] <= cos_dly_reg[i-1];
        end
    end

    // Multiply radius by the cosine magnitude
    logic signed [31:0] c_al;
    logic [30:0]        c_abs;
    bmg_ctl_t           m_ctl_reg;
    logic [61:0]        mag_reg;
    logic               mneg_reg;

    assign c_al  = cos_dly_reg[ALIGN_LAT-1];
    assign c_abs = c_al[31] ? 31'(-c_al) : c_al[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ctl_reg <= '0;
        end
        else
        begin
            m_ctl_reg <= sq_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= root * c_abs;
        mneg_reg <= c_al[31];
    end

    // Round, saturate and sign the word
    logic [62:0]        rsum;
    logic [62:0]        rmag;
    logic signed [15:0] gauss_next;
    logic               sat_next;

    assign rsum = 63'(mag_reg) + RND;
    assign rmag = rsum >> SHIFT;

    always_comb
    begin
        sat_next   = 1'b0;
        gauss_next = mneg_reg ? -$signed(rmag[15:0]) : $signed(rmag[15:0]);
        if (m_ctl_reg.zero)
        begin
            gauss_next = 16'sh7FFF;
            sat_next   = 1'b1;
        end
        else if (!mneg_reg && rmag > 63'd32767)
        begin
            gauss_next = 16'sh7FFF;
            sat_next   = 1'b1;
        end
        else if (mneg_reg && rmag > 63'd32768)
        begin
            gauss_next = 16'sh8000;
            sat_next   = 1'b1;
        end
    end

    logic               done_reg;
    logic signed [15:0] gauss_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        gauss_reg <= gauss_next;
        sat_reg   <= sat_next;
    end

    assign done         = done_reg;
    assign gauss_sample = gauss_reg;
    assign saturated    = sat_reg;

endmodule

FILE: design/bmg_checker.sv
// Port-level checker for the Gaussian sample unit and its bind.
`include "assert_macros.svh"

module bmg_checker #(
    parameter int UNIFORM_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [UNIFORM_BITS-1:0] radius_uniform,
    input logic                    done,
    input logic signed [15:0]      gauss_sample,
    input logic                    saturated
);
    import bmg_pkg::*;

    `BMG_NEVER(a_never_busy, busy, "busy raised")
    `BMG_ASSERT(a_done_follows, (start && !busy) |-> ##RESULT_LAT done, "word lost")
    `BMG_ASSERT(a_done_caused, done |-> $past(start && !busy, RESULT_LAT), "word invented")
    `BMG_ASSERT(a_sat_limit, (done && saturated) |-> (gauss_sample == 16'sh7FFF || gauss_sample == 16'sh8000), "saturated word not at a limit")
    `BMG_ASSERT(a_zero_radius, (start && !busy && radius_uniform == '0) |-> ##RESULT_LAT (saturated && gauss_sample == 16'sh7FFF), "zero radius not clipped")

endmodule

bind box_muller_gaussian_sample_unit bmg_checker #(
    .UNIFORM_BITS (UNIFORM_BITS)
) u_bmg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .radius_uniform (radius_uniform),
    .done           (done),
    .gauss_sample   (gauss_sample),
    .saturated      (saturated)
);
